>>> rtl/ols_pkg.sv
// shared types and codes for the ordered list store
package ols_pkg;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_READ   = 3'd2,
		OP_SEARCH = 3'd3,
		OP_CLEAR  = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_BADPOS   = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ADR_ZERO     = 3'd0,
		ADR_POS      = 3'd1,
		ADR_CNT_DEC  = 3'd2,
		ADR_PTR_DEC  = 3'd3,
		ADR_PTR_INC  = 3'd4,
		ADR_PTR_INC2 = 3'd5
	} rd_adr_t;

	typedef enum logic [1:0] {
		WR_SHIFT_UP   = 2'd0,
		WR_SHIFT_DOWN = 2'd1,
		WR_KEY        = 2'd2
	} wr_sel_t;

	typedef enum logic [1:0] {
		PTR_HOLD = 2'd0,
		PTR_LOAD = 2'd1,
		PTR_DEC  = 2'd2,
		PTR_INC  = 2'd3
	} ptr_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD  = 2'd0,
		CNT_INC   = 2'd1,
		CNT_DEC   = 2'd2,
		CNT_CLEAR = 2'd3
	} cnt_op_t;

	typedef struct packed {
		logic    take;
		logic    clr_res;
		logic    set_err;
		status_t status;
		logic    cap_data;
		logic    cap_found;
		logic    rd_en;
		rd_adr_t rd_adr;
		logic    wr_en;
		wr_sel_t wr_sel;
		ptr_op_t ptr_op;
		cnt_op_t cnt_op;
		logic    load_out;
	} ols_cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    full;
		logic    pos_gt_count;
		logic    pos_ge_count;
		logic    count_zero;
		logic    diff_one;
		logic    diff_two;
		logic    ptr_at_pos;
		logic    key_match;
		logic    out_free;
	} ols_stat_t;

endpackage

>>> rtl/ols_cmd_if.sv
// request channel: operation, position and key
interface ols_cmd_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  opcode;
	logic        [8:0]  position;
	logic signed [31:0] key_value;

	modport source (output valid, output opcode, output position, output key_value,
		input ready);
	modport sink (input valid, input opcode, input position, input key_value,
		output ready);
endinterface

>>> rtl/ols_rsp_if.sv
// response channel: status, data and list size
interface ols_rsp_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  status;
	logic signed [31:0] data_out;
	logic        [7:0]  found_position;
	logic        [8:0]  entry_count;
	logic               is_empty;

	modport source (output valid, output status, output data_out, output found_position,
		output entry_count, output is_empty, input ready);
	modport sink (input valid, input status, input data_out, input found_position,
		input entry_count, input is_empty, output ready);
endinterface

>>> rtl/ordered_list_store.sv
// ordered list store top level
// Ordered list of up to CAPACITY signed 32-bit keys held in one memory with a
// write port and a registered read port. Insert, delete, read, search and clear
// each give one response with status, data, found position, entry count and an
// empty flag. One item is worked at a time. Insert shifts the entries from
// position up to the end one place up, delete shifts the entries above
// position one place down, and search walks from entry 0 to a match or the
// last entry; these walks move one entry per cycle through the memory's
// single read and single write port. A finished response sits in an output
// register, so the next request may be taken while it waits.
// No clearing pass is needed after reset; entries beyond the count are never read.
module ordered_list_store #(
	parameter int CAPACITY = 256
) (
	input logic        clk,
	input logic        arst_n,
	ols_cmd_if.sink    cmd,
	ols_rsp_if.source  rsp
);
	ols_pkg::ols_cmd_t  ctl_cmd;
	ols_pkg::ols_stat_t ctl_stat;

	ols_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.stat      (ctl_stat),
		.cmd       (ctl_cmd)
	);

	ols_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (ctl_cmd),
		.stat               (ctl_stat),
		.opcode             (cmd.opcode),
		.position           (cmd.position),
		.key_value          (cmd.key_value),
		.rsp_ready          (rsp.ready),
		.rsp_valid          (rsp.valid),
		.rsp_status         (rsp.status),
		.rsp_data_out       (rsp.data_out),
		.rsp_found_position (rsp.found_position),
		.rsp_entry_count    (rsp.entry_count),
		.rsp_is_empty       (rsp.is_empty)
	);
endmodule

>>> rtl/ols_datapath.sv
// entry memory, count, walk pointer, result and output registers
module ols_datapath #(
	parameter int CAPACITY = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ols_pkg::ols_cmd_t  cmd,
	output ols_pkg::ols_stat_t stat,
	input  logic        [2:0]  opcode,
	input  logic        [8:0]  position,
	input  logic signed [31:0] key_value,
	input  logic               rsp_ready,
	output logic               rsp_valid,
	output logic        [1:0]  rsp_status,
	output logic signed [31:0] rsp_data_out,
	output logic        [7:0]  rsp_found_position,
	output logic        [8:0]  rsp_entry_count,
	output logic               rsp_is_empty
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 9) ? CW : 9;

	logic [31:0]     mem [CAPACITY];
	logic [31:0]     rdata_q;
	logic [2:0]      op_q;
	logic [8:0]      pos_q;
	logic [31:0]     key_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   ptr_q;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   wr_addr;
	logic [31:0]     wr_data;
	logic [CW-1:0]   diff;
	logic [XW-1:0]   pos_x;
	logic [XW-1:0]   cnt_x;

	ols_pkg::status_t res_status_q;
	logic [31:0]      res_data_q;
	logic [7:0]       res_found_q;

	logic             out_valid_q;
	ols_pkg::status_t out_status_q;
	logic [31:0]      out_data_q;
	logic [7:0]       out_found_q;
	logic [8:0]       out_count_q;
	logic             out_empty_q;

	always_comb begin
		case (cmd.rd_adr)
			ols_pkg::ADR_POS:      rd_addr = AW'(pos_q);
			ols_pkg::ADR_CNT_DEC:  rd_addr = AW'(count_q - CW'(1));
			ols_pkg::ADR_PTR_DEC:  rd_addr = ptr_q - AW'(1);
			ols_pkg::ADR_PTR_INC:  rd_addr = ptr_q + AW'(1);
			ols_pkg::ADR_PTR_INC2: rd_addr = ptr_q + AW'(2);
			default:               rd_addr = '0;
		endcase
	end

	always_comb begin
		case (cmd.wr_sel)
			ols_pkg::WR_SHIFT_UP: begin
				wr_addr = ptr_q + AW'(1);
				wr_data = rdata_q;
			end
			ols_pkg::WR_SHIFT_DOWN: begin
				wr_addr = ptr_q;
				wr_data = rdata_q;
			end
			default: begin
				wr_addr = AW'(pos_q);
				wr_data = key_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// latched item and walk pointer
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q  <= opcode;
			pos_q <= position;
			key_q <= key_value;
		end
		case (cmd.ptr_op)
			ols_pkg::PTR_LOAD: ptr_q <= rd_addr;
			ols_pkg::PTR_DEC:  ptr_q <= ptr_q - AW'(1);
			ols_pkg::PTR_INC:  ptr_q <= ptr_q + AW'(1);
			default:           ptr_q <= ptr_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd.cnt_op)
				ols_pkg::CNT_INC:   count_q <= count_q + CW'(1);
				ols_pkg::CNT_DEC:   count_q <= count_q - CW'(1);
				ols_pkg::CNT_CLEAR: count_q <= '0;
				default:            count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_res) begin
			res_status_q <= cmd.set_err ? cmd.status : ols_pkg::ST_OK;
			res_data_q   <= '0;
			res_found_q  <= '0;
		end else begin
			if (cmd.set_err) begin
				res_status_q <= cmd.status;
			end
			if (cmd.cap_data) begin
				res_data_q <= rdata_q;
			end
			if (cmd.cap_found) begin
				res_found_q <= 8'(ptr_q);
			end
		end
	end

	// output register, frees the walk from the consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_data_q   <= res_data_q;
			out_found_q  <= res_found_q;
			out_count_q  <= 9'(count_q);
			out_empty_q  <= (count_q == '0);
		end
	end

	assign pos_x = XW'(pos_q);
	assign cnt_x = XW'(count_q);
	assign diff  = count_q - CW'(ptr_q);

	assign stat.op           = ols_pkg::opcode_t'(op_q);
	assign stat.full         = (count_q == CW'(CAPACITY));
	assign stat.pos_gt_count = (pos_x > cnt_x);
	assign stat.pos_ge_count = (pos_x >= cnt_x);
	assign stat.count_zero   = (count_q == '0);
	assign stat.diff_one     = (diff == CW'(1));
	assign stat.diff_two     = (diff == CW'(2));
	assign stat.ptr_at_pos   = (ptr_q == AW'(pos_q));
	assign stat.key_match    = (rdata_q == key_q);
	assign stat.out_free     = !out_valid_q || rsp_ready;

	assign rsp_valid          = out_valid_q;
	assign rsp_status         = out_status_q;
	assign rsp_data_out       = out_data_q;
	assign rsp_found_position = out_found_q;
	assign rsp_entry_count    = out_count_q;
	assign rsp_is_empty       = out_empty_q;
endmodule

>>> rtl/ols_ctrl.sv
// sequencer for decode, shift walks, search walk and result hand-off
module ols_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  ols_pkg::ols_stat_t stat,
	output ols_pkg::ols_cmd_t  cmd
);
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_INS_SHIFT,
		S_INS_PUT,
		S_DEL_FIRST,
		S_DEL_SHIFT,
		S_RD_WAIT,
		S_SRCH,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd.take = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.clr_res = 1'b1;
				state_d     = S_DONE;
				case (stat.op)
					ols_pkg::OP_INSERT: begin
						if (stat.full) begin
							cmd.set_err = 1'b1;
							cmd.status  = ols_pkg::ST_FULL;
						end else if (stat.pos_gt_count) begin
							cmd.set_err = 1'b1;
							cmd.status  = ols_pkg::ST_BADPOS;
						end else if (stat.pos_ge_count) begin
							state_d = S_INS_PUT;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_adr = ols_pkg::ADR_CNT_DEC;
							cmd.ptr_op = ols_pkg::PTR_LOAD;
							state_d    = S_INS_SHIFT;
						end
					end
					ols_pkg::OP_DELETE: begin
						if (stat.pos_ge_count) begin
							cmd.set_err = 1'b1;
							cmd.status  = ols_pkg::ST_BADPOS;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_adr = ols_pkg::ADR_POS;
							cmd.ptr_op = ols_pkg::PTR_LOAD;
							state_d    = S_DEL_FIRST;
						end
					end
					ols_pkg::OP_READ: begin
						if (stat.pos_ge_count) begin
							cmd.set_err = 1'b1;
							cmd.status  = ols_pkg::ST_BADPOS;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_adr = ols_pkg::ADR_POS;
							state_d    = S_RD_WAIT;
						end
					end
					ols_pkg::OP_SEARCH: begin
						if (stat.count_zero) begin
							cmd.set_err = 1'b1;
							cmd.status  = ols_pkg::ST_NOTFOUND;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_adr = ols_pkg::ADR_ZERO;
							cmd.ptr_op = ols_pkg::PTR_LOAD;
							state_d    = S_SRCH;
						end
					end
					ols_pkg::OP_CLEAR: begin
						cmd.cnt_op = ols_pkg::CNT_CLEAR;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_INS_SHIFT: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = ols_pkg::WR_SHIFT_UP;
				if (stat.ptr_at_pos) begin
					state_d = S_INS_PUT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_adr = ols_pkg::ADR_PTR_DEC;
					cmd.ptr_op = ols_pkg::PTR_DEC;
				end
			end
			S_INS_PUT: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = ols_pkg::WR_KEY;
				cmd.cnt_op = ols_pkg::CNT_INC;
				state_d    = S_DONE;
			end
			S_DEL_FIRST: begin
				cmd.cap_data = 1'b1;
				if (stat.diff_one) begin
					cmd.cnt_op = ols_pkg::CNT_DEC;
					state_d    = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_adr = ols_pkg::ADR_PTR_INC;
					state_d    = S_DEL_SHIFT;
				end
			end
			S_DEL_SHIFT: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = ols_pkg::WR_SHIFT_DOWN;
				cmd.ptr_op = ols_pkg::PTR_INC;
				if (stat.diff_two) begin
					cmd.cnt_op = ols_pkg::CNT_DEC;
					state_d    = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_adr = ols_pkg::ADR_PTR_INC2;
				end
			end
			S_RD_WAIT: begin
				cmd.cap_data = 1'b1;
				state_d      = S_DONE;
			end
			S_SRCH: begin
				if (stat.key_match) begin
					cmd.cap_found = 1'b1;
					state_d       = S_DONE;
				end else if (stat.diff_one) begin
					cmd.set_err = 1'b1;
					cmd.status  = ols_pkg::ST_NOTFOUND;
					state_d     = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_adr = ols_pkg::ADR_PTR_INC;
					cmd.ptr_op = ols_pkg::PTR_INC;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd_ready = (state_q == S_IDLE);
endmodule
